>>> design/adf_pkg.sv
// shared types, constants and codes for the advertising data field parser
package adf_pkg;

    localparam int NAME_BYTES_DEF  = 32;
    localparam int MAKER_BYTES_DEF = 16;
    localparam int MAX_UUIDS_DEF   = 8;

    localparam logic [7:0] AD_UUID_SOME    = 8'h02;
    localparam logic [7:0] AD_UUID_ALL     = 8'h03;
    localparam logic [7:0] AD_NAME_SHORT   = 8'h08;
    localparam logic [7:0] AD_NAME_FULL    = 8'h09;
    localparam logic [7:0] AD_POWER_LEVEL  = 8'h0A;
    localparam logic [7:0] AD_MAKER        = 8'hFF;
    localparam logic [7:0] POWER_LEVEL_DEF = 8'h81;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_MAKER   = 2'd1;
    localparam logic [1:0] KIND_UUID    = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] payload_length;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [4:0]        element_index;
        logic [15:0]       element_value;
        logic signed [7:0] power_dbm;
        logic [4:0]        name_length;
        logic [4:0]        manufacturer_length;
        logic [3:0]        uuid_count;
        logic              run_end;
    } out_word_t;

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_DATA = 4'b0100,
        PH_STOP = 4'b1000
    } parse_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_FETCH   = 4'b0010,
        ST_EMIT    = 4'b0100,
        ST_SUMMARY = 4'b1000
    } ctrl_state_t;

    typedef struct packed {
        logic parse;
        logic start_drain;
        logic next_list;
        logic load_elem;
        logic load_summary;
    } ctrl_cmd_t;

    typedef struct packed {
        logic list_done;
        logic list_is_summary;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/adf_ram.sv
// generic single write port ram with registered read
module adf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

>>> design/adf_ctrl.sv
// drain controller state machine
module adf_ctrl import adf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       final_byte,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.parse = s_valid;
                if (s_valid && final_byte) begin
                    cmd.start_drain = 1'b1;
                    state_next      = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (status.list_is_summary) begin
                    state_next = ST_SUMMARY;
                end else if (status.list_done) begin
                    cmd.next_list = 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_elem = 1'b1;
                    state_next    = ST_FETCH;
                end
            end
            ST_SUMMARY: begin
                if (status.out_free) begin
                    cmd.load_summary = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/adf_datapath.sv
// field walker, element stores and output register
module adf_datapath import adf_pkg::*; #(
    parameter int NAME_BYTES  = NAME_BYTES_DEF,
    parameter int MAKER_BYTES = MAKER_BYTES_DEF,
    parameter int MAX_UUIDS   = MAX_UUIDS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_word_t   s_word,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_word
);

    localparam int NAW = $clog2(NAME_BYTES);
    localparam int MAW = (MAKER_BYTES > 1) ? $clog2(MAKER_BYTES) : 1;
    localparam int UAW = (MAX_UUIDS > 1) ? $clog2(MAX_UUIDS) : 1;

    parse_phase_t phase_reg, phase_next;
    logic [7:0]   pos_reg, pos_next;
    logic [7:0]   rem_reg, rem_next;
    logic [7:0]   rem_dec;
    logic [7:0]   type_reg, type_next;
    logic [7:0]   dindex_reg, dindex_next;
    logic [4:0]   name_count_reg, name_count_next;
    logic [4:0]   maker_count_reg, maker_count_next;
    logic [3:0]   uuid_total_reg, uuid_total_next;
    logic [7:0]   uuid_low_reg, uuid_low_next;
    logic [7:0]   power_reg, power_next;
    logic [1:0]   list_reg, list_next;
    logic [4:0]   idx_reg, idx_next;
    logic         m_valid_reg, m_valid_next;
    out_word_t    out_reg, out_next;

    logic         name_we, maker_we, uuid_we;
    logic [7:0]   name_rdata, maker_rdata;
    logic [15:0]  uuid_rdata;
    logic [15:0]  elem_value;
    logic [7:0]   b;
    logic [7:0]   len;

    assign b   = s_word.data_byte;
    assign len = s_word.payload_length;

    adf_ram #(.WIDTH(8), .DEPTH(NAME_BYTES), .AW(NAW)) u_name_ram (
        .aclk  (aclk),
        .we    (name_we),
        .waddr (name_count_reg[NAW-1:0]),
        .wdata (b),
        .raddr (idx_reg[NAW-1:0]),
        .rdata (name_rdata)
    );

    adf_ram #(.WIDTH(8), .DEPTH(MAKER_BYTES), .AW(MAW)) u_maker_ram (
        .aclk  (aclk),
        .we    (maker_we),
        .waddr (maker_count_reg[MAW-1:0]),
        .wdata (b),
        .raddr (idx_reg[MAW-1:0]),
        .rdata (maker_rdata)
    );

    adf_ram #(.WIDTH(16), .DEPTH(MAX_UUIDS), .AW(UAW)) u_uuid_ram (
        .aclk  (aclk),
        .we    (uuid_we),
        .waddr (uuid_total_reg[UAW-1:0]),
        .wdata ({b, uuid_low_reg}),
        .raddr (idx_reg[UAW-1:0]),
        .rdata (uuid_rdata)
    );

    // walk the length / type / data structures
    always_comb begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        rem_next         = rem_reg;
        type_next        = type_reg;
        dindex_next      = dindex_reg;
        name_count_next  = name_count_reg;
        maker_count_next = maker_count_reg;
        uuid_total_next  = uuid_total_reg;
        uuid_low_next    = uuid_low_reg;
        power_next       = power_reg;
        name_we          = 1'b0;
        maker_we         = 1'b0;
        uuid_we          = 1'b0;
        rem_dec          = (rem_reg != 8'd0) ? rem_reg - 8'd1 : rem_reg;
        if (cmd.parse) begin
            if (pos_reg != 8'hFF) begin
                pos_next = pos_reg + 8'd1;
            end
            if (pos_reg < len && phase_reg != PH_STOP) begin
                if (phase_reg == PH_LEN) begin
                    if (b == 8'd0 || ({1'b0, pos_reg} + 9'd1 + {1'b0, b}) > {1'b0, len}) begin
                        phase_next = PH_STOP;
                    end else begin
                        rem_next   = b;
                        phase_next = PH_TYPE;
                    end
                end else begin
                    if (phase_reg == PH_TYPE) begin
                        type_next   = b;
                        dindex_next = 8'd0;
                        if (b inside {AD_NAME_SHORT, AD_NAME_FULL}) begin
                            name_count_next = 5'd0;
                        end else if (b == AD_MAKER) begin
                            maker_count_next = 5'd0;
                        end
                    end else begin
                        if (type_reg inside {AD_NAME_SHORT, AD_NAME_FULL}) begin
                            if (name_count_reg < 5'(NAME_BYTES - 1)) begin
                                name_we         = 1'b1;
                                name_count_next = name_count_reg + 5'd1;
                            end
                        end else if (type_reg == AD_MAKER) begin
                            if (maker_count_reg < 5'(MAKER_BYTES)) begin
                                maker_we         = 1'b1;
                                maker_count_next = maker_count_reg + 5'd1;
                            end
                        end else if (type_reg inside {AD_UUID_SOME, AD_UUID_ALL}) begin
                            if (!dindex_reg[0]) begin
                                uuid_low_next = b;
                            end else if (uuid_total_reg < 4'(MAX_UUIDS)) begin
                                uuid_we         = 1'b1;
                                uuid_total_next = uuid_total_reg + 4'd1;
                            end
                        end else if (type_reg == AD_POWER_LEVEL) begin
                            if (dindex_reg == 8'd0) begin
                                power_next = b;
                            end
                        end
                        if (dindex_reg != 8'hFF) begin
                            dindex_next = dindex_reg + 8'd1;
                        end
                    end
                    rem_next   = rem_dec;
                    phase_next = (rem_dec == 8'd0) ? PH_LEN : PH_DATA;
                end
            end
        end
        if (cmd.load_summary) begin
            phase_next       = PH_LEN;
            pos_next         = 8'd0;
            rem_next         = 8'd0;
            type_next        = 8'd0;
            dindex_next      = 8'd0;
            name_count_next  = 5'd0;
            maker_count_next = 5'd0;
            uuid_total_next  = 4'd0;
            uuid_low_next    = 8'd0;
            power_next       = POWER_LEVEL_DEF;
        end
    end

    // drain list walk and status
    always_comb begin
        list_next = list_reg;
        idx_next  = idx_reg;
        if (cmd.start_drain) begin
            list_next = KIND_NAME;
            idx_next  = 5'd0;
        end else if (cmd.next_list) begin
            list_next = list_reg + 2'd1;
            idx_next  = 5'd0;
        end else if (cmd.load_elem) begin
            idx_next = idx_reg + 5'd1;
        end
        case (list_reg)
            KIND_NAME:  status.list_done = (idx_reg >= name_count_reg);
            KIND_MAKER: status.list_done = (idx_reg >= maker_count_reg);
            KIND_UUID:  status.list_done = (idx_reg >= {1'b0, uuid_total_reg});
            default:    status.list_done = 1'b1;
        endcase
        status.list_is_summary = (list_reg == KIND_SUMMARY);
        status.out_free        = !m_valid_reg || m_ready;
    end

    always_comb begin
        case (list_reg)
            KIND_NAME:  elem_value = {8'd0, name_rdata};
            KIND_MAKER: elem_value = {8'd0, maker_rdata};
            KIND_UUID:  elem_value = uuid_rdata;
            default:    elem_value = 16'd0;
        endcase
    end

    // output word register
    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.load_elem) begin
            out_next               = '0;
            out_next.kind          = list_reg;
            out_next.element_index = idx_reg;
            out_next.element_value = elem_value;
            m_valid_next           = 1'b1;
        end else if (cmd.load_summary) begin
            out_next                     = '0;
            out_next.kind                = KIND_SUMMARY;
            out_next.power_dbm           = power_reg;
            out_next.name_length         = name_count_reg;
            out_next.manufacturer_length = maker_count_reg;
            out_next.uuid_count          = uuid_total_reg;
            out_next.run_end             = 1'b1;
            m_valid_next                 = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_LEN;
            pos_reg         <= 8'd0;
            rem_reg         <= 8'd0;
            type_reg        <= 8'd0;
            dindex_reg      <= 8'd0;
            name_count_reg  <= 5'd0;
            maker_count_reg <= 5'd0;
            uuid_total_reg  <= 4'd0;
            uuid_low_reg    <= 8'd0;
            power_reg       <= POWER_LEVEL_DEF;
            list_reg        <= KIND_NAME;
            idx_reg         <= 5'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            rem_reg         <= rem_next;
            type_reg        <= type_next;
            dindex_reg      <= dindex_next;
            name_count_reg  <= name_count_next;
            maker_count_reg <= maker_count_next;
            uuid_total_reg  <= uuid_total_next;
            uuid_low_reg    <= uuid_low_next;
            power_reg       <= power_next;
            list_reg        <= list_next;
            idx_reg         <= idx_next;
            m_valid_reg     <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

endmodule

>>> design/adv_data_field_parser.sv
// advertising data field parser, top level
//
// input channel s_*: one payload byte per word, with the payload length and a
// last-byte flag. non-last bytes are parsed in the cycle they are taken, so
// the block takes one byte per cycle while it is collecting.
// output channel m_*: after the last byte the block drains the stored name
// bytes, then manufacturer bytes, then 16-bit service uuids, then a summary
// word with run_end set. each element is a store read in the fetch state, then
// an output register load in the emit state; the end of each list takes a
// further fetch state, and the summary a list check, then an output register
// load. s_ready is low during the drain and rises again the cycle after the
// summary is loaded, with the walker and counts cleared and transmit power
// back to -127 for the next payload; the stores keep their contents.
// a stalled receiver holds the output register and the drain waits on it.
// reset (aresetn low, synchronous) clears the walker, counts, transmit power
// to -127 and drops m_valid; store contents are left as they are.
module adv_data_field_parser import adf_pkg::*; #(
    parameter int NAME_BYTES  = NAME_BYTES_DEF,
    parameter int MAKER_BYTES = MAKER_BYTES_DEF,
    parameter int MAX_UUIDS   = MAX_UUIDS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    adf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .final_byte (s_word.final_byte),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    adf_datapath #(
        .NAME_BYTES  (NAME_BYTES),
        .MAKER_BYTES (MAKER_BYTES),
        .MAX_UUIDS   (MAX_UUIDS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    a_summary_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_summary |=> m_valid && m_word.run_end && s_ready)
        else $error("summary word not presented");

    a_drain_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_word.final_byte |=> !s_ready)
        else $error("input taken during drain");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_elem || cmd.load_summary |-> status.out_free)
        else $error("output register overwritten");

endmodule

>>> test/adv_data_field_parser_tb.sv
// testbench for the advertising data field parser: random ad payloads, predicted drain words
`timescale 1ns / 1ps

module adv_data_field_parser_tb import adf_pkg::*;;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_BYTES = 200;
    localparam int DRAIN_SETTLE = 20;

    typedef logic [7:0] byte_q_t[$];

    class ad_field_tracker;
        parse_phase_t phase;
        logic [7:0]   pos;
        logic [7:0]   remaining;
        logic [7:0]   ftype;
        logic [7:0]   didx;
        logic [7:0]   name_mem[NAME_BYTES_DEF];
        int           name_cnt;
        logic [7:0]   maker_mem[MAKER_BYTES_DEF];
        int           maker_cnt;
        logic [15:0]  uuid_mem[MAX_UUIDS_DEF];
        int           uuid_cnt;
        logic [7:0]   uuid_low;
        logic [7:0]   power;
        out_word_t    owed_words[$];
        int           errors;

        function new();
            errors = 0;
            clear_payload();
        endfunction

        function void clear_payload();
            phase     = PH_LEN;
            pos       = 8'd0;
            remaining = 8'd0;
            ftype     = 8'd0;
            didx      = 8'd0;
            name_cnt  = 0;
            maker_cnt = 0;
            uuid_cnt  = 0;
            uuid_low  = 8'd0;
            power     = POWER_LEVEL_DEF;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        function void store_data(logic [7:0] b);
            if (ftype == AD_NAME_SHORT || ftype == AD_NAME_FULL) begin
                if (name_cnt < NAME_BYTES_DEF - 1) begin
                    name_mem[name_cnt] = b;
                    name_cnt++;
                end
            end else if (ftype == AD_MAKER) begin
                if (maker_cnt < MAKER_BYTES_DEF) begin
                    maker_mem[maker_cnt] = b;
                    maker_cnt++;
                end
            end else if (ftype == AD_UUID_SOME || ftype == AD_UUID_ALL) begin
                if (!didx[0]) begin
                    uuid_low = b;
                end else if (uuid_cnt < MAX_UUIDS_DEF) begin
                    uuid_mem[uuid_cnt] = {b, uuid_low};
                    uuid_cnt++;
                end
            end else if (ftype == AD_POWER_LEVEL) begin
                if (didx == 8'd0) begin
                    power = b;
                end
            end
            if (didx != 8'hFF) begin
                didx++;
            end
        endfunction

        function void walk_byte(logic [7:0] b, logic [7:0] len);
            logic [7:0] p;
            p = pos;
            if (pos != 8'hFF) begin
                pos++;
            end
            if (p >= len || phase == PH_STOP) begin
                return;
            end
            if (phase == PH_LEN) begin
                if (b == 8'd0 || int'(p) + 1 + int'(b) > int'(len)) begin
                    phase = PH_STOP;
                end else begin
                    remaining = b;
                    phase = PH_TYPE;
                end
                return;
            end
            if (phase == PH_TYPE) begin
                ftype = b;
                didx = 8'd0;
                if (b == AD_NAME_SHORT || b == AD_NAME_FULL) begin
                    name_cnt = 0;
                end else if (b == AD_MAKER) begin
                    maker_cnt = 0;
                end
            end else begin
                store_data(b);
            end
            if (remaining != 8'd0) begin
                remaining--;
            end
            phase = (remaining == 8'd0) ? PH_LEN : PH_DATA;
        endfunction

        function void note_byte(in_word_t w);
            out_word_t e;
            walk_byte(w.data_byte, w.payload_length);
            if (!w.final_byte) begin
                return;
            end
            for (int i = 0; i < name_cnt; i++) begin
                e = '0;
                e.kind = KIND_NAME;
                e.element_index = i[4:0];
                e.element_value = {8'h00, name_mem[i]};
                owed_words.push_back(e);
            end
            for (int i = 0; i < maker_cnt; i++) begin
                e = '0;
                e.kind = KIND_MAKER;
                e.element_index = i[4:0];
                e.element_value = {8'h00, maker_mem[i]};
                owed_words.push_back(e);
            end
            for (int i = 0; i < uuid_cnt; i++) begin
                e = '0;
                e.kind = KIND_UUID;
                e.element_index = i[4:0];
                e.element_value = uuid_mem[i];
                owed_words.push_back(e);
            end
            e = '0;
            e.kind = KIND_SUMMARY;
            e.power_dbm = power;
            e.name_length = name_cnt[4:0];
            e.manufacturer_length = maker_cnt[4:0];
            e.uuid_count = uuid_cnt[3:0];
            e.run_end = 1'b1;
            owed_words.push_back(e);
            clear_payload();
        endfunction

        function void field_diff(string fname, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                if (errors < 60) begin
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, fname, exp_v, act_v);
                end
            end
        endfunction

        function void check_word(out_word_t got);
            out_word_t e;
            if (owed_words.size() == 0) begin
                errors++;
                if (errors < 60) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                end
                return;
            end
            e = owed_words.pop_front();
            field_diff("kind", int'(e.kind), int'(got.kind));
            field_diff("element_index", int'(e.element_index), int'(got.element_index));
            field_diff("element_value", int'(e.element_value), int'(got.element_value));
            field_diff("power_dbm", int'(e.power_dbm), int'(got.power_dbm));
            field_diff("name_length", int'(e.name_length), int'(got.name_length));
            field_diff("manufacturer_length", int'(e.manufacturer_length),
                       int'(got.manufacturer_length));
            field_diff("uuid_count", int'(e.uuid_count), int'(got.uuid_count));
            field_diff("run_end", int'(e.run_end), int'(got.run_end));
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    ad_field_tracker tracker = new();
    int              cycle_count;

    adv_data_field_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_byte(s_word);
            end
            if (m_valid && m_ready) begin
                tracker.check_word(m_word);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    // receiver stalls, with calm stretches
    initial begin
        int  hold;
        int  span;
        bit  steady;
        hold = 0;
        span = 0;
        steady = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                span = $urandom_range(20, 150);
            end
            span--;
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 2) == 0) begin
                    hold = pick_gap();
                end
            end
        end
    end

    task automatic push_word(input in_word_t w);
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_payload(input byte_q_t bytes, input logic [7:0] len);
        in_word_t w;
        int       gap;
        bit       calm;
        calm = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < bytes.size(); i++) begin
            w.data_byte = bytes[i];
            w.payload_length = len;
            w.final_byte = (i == bytes.size() - 1);
            push_word(w);
            gap = calm ? 0 : pick_gap();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic byte_q_t build_fields(int target);
        byte_q_t    q;
        logic [7:0] ftype;
        int         dlen;
        bit         long_one;
        while (q.size() < target) begin
            long_one = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    ftype = $urandom_range(0, 1) ? AD_NAME_FULL : AD_NAME_SHORT;
                    dlen = long_one ? $urandom_range(28, 40) : $urandom_range(0, 10);
                end
                2, 3: begin
                    ftype = AD_MAKER;
                    dlen = long_one ? $urandom_range(14, 22) : $urandom_range(0, 8);
                end
                4, 5: begin
                    ftype = $urandom_range(0, 1) ? AD_UUID_ALL : AD_UUID_SOME;
                    dlen = long_one ? $urandom_range(12, 20) : $urandom_range(0, 7);
                end
                6, 7: begin
                    ftype = AD_POWER_LEVEL;
                    dlen = $urandom_range(0, 2);
                end
                default: begin
                    ftype = 8'($urandom_range(0, 255));
                    dlen = $urandom_range(0, 4);
                end
            endcase
            q.push_back(8'(dlen + 1));
            q.push_back(ftype);
            for (int i = 0; i < dlen; i++) begin
                q.push_back(8'($urandom_range(0, 255)));
            end
        end
        return q;
    endfunction

    function automatic void build_payload(output byte_q_t q, output logic [7:0] len);
        byte_q_t base;
        int      cut;
        base = build_fields($urandom_range(3, 45));
        q = base;
        len = 8'(base.size());
        case ($urandom_range(0, 11))
            6: begin
                // extra bytes past the declared length
                repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(0, 255)));
            end
            7: begin
                // zero length ends the walk, garbage follows
                q.push_back(8'h00);
                repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
                len = 8'(q.size());
            end
            8: begin
                // declared length cuts into the structures
                len = 8'(base.size() - $urandom_range(1, 3));
            end
            9: begin
                // last byte flagged before the declared length
                len = 8'($urandom_range(base.size() + 1, 255));
                cut = $urandom_range(1, base.size());
                q.delete();
                for (int i = 0; i < cut; i++) begin
                    q.push_back(base[i]);
                end
            end
            10: begin
                q.delete();
                repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
                len = 8'($urandom_range(0, 255));
            end
            11: begin
                q.delete();
                q.push_back(8'($urandom_range(0, 255)));
                len = 8'd0;
            end
            default: begin
            end
        endcase
    endfunction

    initial begin
        byte_q_t    pay;
        logic [7:0] plen;
        int         sent;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_word  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty advertisement
        pay = {8'h3C};
        send_payload(pay, 8'd0);
        // one of each stored element, power at its negative extreme
        pay = {8'h02, AD_POWER_LEVEL, 8'h80, 8'h02, AD_NAME_SHORT, 8'h41,
               8'h03, AD_UUID_SOME, 8'hFF, 8'h00, 8'h02, AD_MAKER, 8'h7F};
        send_payload(pay, 8'd13);
        // name replaced by an empty one, power field with no data, zero length stop
        pay = {8'h02, AD_NAME_FULL, 8'h5A, 8'h01, AD_NAME_SHORT, 8'h01, AD_POWER_LEVEL,
               8'h00, 8'hFF};
        send_payload(pay, 8'd9);
        // overrunning structure, then a byte past the declared length
        pay = {8'hFE, 8'h01, 8'h02, 8'hAA};
        send_payload(pay, 8'd3);
        // early last byte inside a uuid field
        pay = {8'h03, AD_UUID_ALL, 8'hEE};
        send_payload(pay, 8'd200);

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            build_payload(pay, plen);
            send_payload(pay, plen);
            sent += pay.size();
        end
        s_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
